/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the key debouncer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (reset is active low)
`define KDB_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("kdb: assertion failed");

// Same, on the block's own clock and reset
`define KDB_ASSERT(lbl, prop) `KDB_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)

`endif

/* hw/rtl/kdb_pkg.sv */
// Package for the key debouncer: sizes, codes and shared structs.
// No dependencies; imported by kdb_key_unit and the top level.
package kdb_pkg;

    localparam int NUM_KEYS = 3;   // keys with state, 1..8
    localparam int PIN_BITS = 3;   // keys that have a pin bit in a sample
    localparam int KEY_W    = 3;
    localparam int NOW_W    = 32;
    localparam int CFG_W    = 16;
    localparam int EV_W     = 2;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    // item modes
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    // event codes
    localparam logic [EV_W-1:0] EV_RELEASE = 2'd0;
    localparam logic [EV_W-1:0] EV_PRESS   = 2'd1;
    localparam logic [EV_W-1:0] EV_LONG    = 2'd2;

    // register index, taken from paddr[2]
    localparam logic REG_DEBOUNCE   = 1'b0;
    localparam logic REG_LONG_PRESS = 1'b1;

    // config reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd15;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd500;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
    } t_kdb_cfg;

    // per-key command for the item leaving the input register
    typedef struct packed {
        logic             en;         // item advances this cycle
        logic             sample;     // sample item
        logic             query_sel;  // query item naming this key
        logic             pin;        // raw level of this key
        logic [NOW_W-1:0] now_ms;
    } t_kdb_cmd;

endpackage

/* hw/rtl/key_debounce_with_long_press_top.sv */
// Key debouncer with press-edge and long-press detection, top level.
// Input transactions pass the input register and then the result register.
// Throughput: one transaction per cycle unless the result register is stalled; all key
// state updates as an item moves from the input register to the result register.
// Reset (synchronous, active low): keys released, timers idle, registers at
// debounce_ms = 15 and long_press_ms = 500. Depends on kdb_pkg, kdb_key_unit.
`include "assert_macros.svh"

module key_debounce_with_long_press_top
    import kdb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_mode,
    input  logic [NOW_W-1:0]  i_now_ms,
    input  logic [PIN_BITS-1:0] i_pin_levels,
    input  logic [KEY_W-1:0]  i_key_index,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [EV_W-1:0]   o_event_res,
    output logic [PIN_BITS-1:0] o_stable_levels,
    // APB configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_kdb_cfg           r_cfg;
    logic               r_s1_vld;
    logic               r_s1_mode;
    logic [NOW_W-1:0]   r_s1_now;
    logic [PIN_BITS-1:0] r_s1_pins;
    logic [KEY_W-1:0]   r_s1_key;
    logic               r_out_vld;
    logic [EV_W-1:0]    r_out_event;
    logic [PIN_BITS-1:0] r_out_stable;
    logic               w_advance;
    logic               w_cfg_wr;
    logic [EV_W-1:0]    w_event;
    logic [PIN_BITS-1:0] w_stable;
    t_kdb_cmd           w_cmd [NUM_KEYS];
    logic [EV_W-1:0]    w_key_ev [NUM_KEYS];
    logic [NUM_KEYS-1:0] w_key_stable;

    // configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= DEBOUNCE_RST;
            r_cfg.long_press_ms <= LONG_PRESS_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_DEBOUNCE:   r_cfg.debounce_ms   <= pwdata[CFG_W-1:0];
                REG_LONG_PRESS: r_cfg.long_press_ms <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DEBOUNCE:   prdata = {{(APB_DW-CFG_W){1'b0}}, r_cfg.debounce_ms};
            REG_LONG_PRESS: prdata = {{(APB_DW-CFG_W){1'b0}}, r_cfg.long_press_ms};
            default:        prdata = '0;
        endcase
    end

    // handshake: input register drains whenever the result register is free
    assign w_advance  = r_s1_vld && !(r_out_vld && i_out_stall);
    assign o_in_stall = r_s1_vld && r_out_vld && i_out_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_mode <= i_mode;
            r_s1_now  <= i_now_ms;
            r_s1_pins <= i_pin_levels;
            r_s1_key  <= i_key_index;
        end
    end

    // per-key units
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        logic w_pin;
        if (k < PIN_BITS) begin : g_pin
            assign w_pin = r_s1_pins[k];
        end else begin : g_nopin
            assign w_pin = 1'b1;   // keys without a pin read released
        end

        assign w_cmd[k] = '{
            en:        w_advance,
            sample:    (r_s1_mode == MODE_SAMPLE),
            query_sel: (r_s1_mode == MODE_QUERY) && (r_s1_key == KEY_W'(k)),
            pin:       w_pin,
            now_ms:    r_s1_now
        };

        kdb_key_unit u_key (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cfg        (r_cfg),
            .i_cmd        (w_cmd[k]),
            .o_event      (w_key_ev[k]),
            .o_stable_nxt (w_key_stable[k])
        );
    end

    // merge: at most one key is selected, unknown keys select none
    always_comb begin
        w_event = EV_RELEASE;
        for (int k = 0; k < NUM_KEYS; k++) begin
            w_event = w_event | w_key_ev[k];
        end
    end

    // pack stable levels, keys without state read released
    always_comb begin
        w_stable = '1;
        for (int k = 0; k < PIN_BITS; k++) begin
            if (k < NUM_KEYS) begin
                w_stable[k] = w_key_stable[k];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_advance) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_event  <= w_event;
            r_out_stable <= w_stable;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_event_res     = r_out_event;
    assign o_stable_levels = r_out_stable;

    // an item leaving the input register always lands in the result register
    `KDB_ASSERT(a_advance_lands, w_advance |=> o_out_valid)
    // a sample transaction reports release
    `KDB_ASSERT(a_sample_release, (w_advance && (r_s1_mode == MODE_SAMPLE)) |=> (o_event_res == EV_RELEASE))
    // merged event is always a defined code
    `KDB_ASSERT(a_event_code, o_out_valid |-> (o_event_res <= EV_LONG))

endmodule

/* hw/rtl/kdb_key_unit.sv */
// State and update logic of one key: raw/stable/reported level and settle timer.
// Depends on kdb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kdb_key_unit
    import kdb_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_kdb_cfg        i_cfg,
    input  t_kdb_cmd        i_cmd,
    output logic [EV_W-1:0] o_event,
    output logic            o_stable_nxt
);

    logic             r_raw, n_raw;
    logic             r_stable, n_stable;
    logic             r_reported, n_reported;
    logic             r_active, n_active;
    logic [NOW_W-1:0] r_change_time, n_change_time;
    logic [NOW_W-1:0] w_diff;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw         <= 1'b1;
            r_stable      <= 1'b1;
            r_reported    <= 1'b1;
            r_active      <= 1'b0;
            r_change_time <= '0;
        end else begin
            r_raw         <= n_raw;
            r_stable      <= n_stable;
            r_reported    <= n_reported;
            r_active      <= n_active;
            r_change_time <= n_change_time;
        end
    end

    // elapsed time since last raw change, wraps mod 2^32
    assign w_diff = i_cmd.now_ms - r_change_time;

    // sample and query update
    always_comb begin
        n_raw         = r_raw;
        n_stable      = r_stable;
        n_reported    = r_reported;
        n_active      = r_active;
        n_change_time = r_change_time;
        o_event       = EV_RELEASE;
        if (i_cmd.en && i_cmd.sample) begin
            priority if (i_cmd.pin != r_raw) begin
                // level changed: restart settle timer
                n_raw         = i_cmd.pin;
                n_change_time = i_cmd.now_ms;
                n_active      = 1'b1;
            end else if (r_active && (w_diff >= {16'b0, i_cfg.debounce_ms})) begin
                n_stable = i_cmd.pin;
                n_active = 1'b0;
            end
        end else if (i_cmd.en && i_cmd.query_sel) begin
            priority if (!r_stable && r_reported) begin
                n_reported = 1'b0;
                o_event    = EV_PRESS;
            end else if (r_stable && !r_reported) begin
                n_reported = 1'b1;   // release edge, reported as release
            end else if (!r_stable && (w_diff > {16'b0, i_cfg.long_press_ms})) begin
                o_event = EV_LONG;
            end
        end
    end

    assign o_stable_nxt = n_stable;

    // stable level moves only on a sample
    `KDB_ASSERT(a_stable_on_sample, !(i_cmd.en && i_cmd.sample) |=> $stable(r_stable))
    // reported level moves only on a query of this key
    `KDB_ASSERT(a_rep_on_query, !(i_cmd.en && i_cmd.query_sel) |=> $stable(r_reported))
    // a raw change arms the timer with the item's timestamp
    `KDB_ASSERT(a_change_arms, (i_cmd.en && i_cmd.sample && (i_cmd.pin != r_raw)) |=> (r_active && (r_change_time == $past(i_cmd.now_ms))))

endmodule
